/* src/sorted_timeout_queue_assert.svh */
// ----------------------------------------------------------------------------
// sorted timeout queue assertion macros
// shared concurrent assertion forms, sampled on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* src/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// types and codes shared by the sorted timeout queue and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

   localparam int unsigned KEY_W    = 32;
   localparam int unsigned ID_W     = 10;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_ADJUST = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_EXPIRED   = 3'd3,
      STATUS_NONE      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_FIND   = 3'd1,
      ST_REMOVE = 3'd2,
      ST_INSERT = 3'd3,
      ST_REPLY  = 3'd4,
      ST_TICK   = 3'd5
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* src/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell
// one slot of the sorted chain: holds an expiry and its owner id
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell import stq_pkg::*; #(
   parameter int ID_BITS = 10
) (
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic [ID_BITS-1:0] new_id,
   input  wire logic               occupied,
   input  wire logic               rm,
   input  wire logic               left_place,
   input  wire logic [KEY_W-1:0]   left_key,
   input  wire logic [ID_BITS-1:0] left_id,
   input  wire logic [KEY_W-1:0]   right_key,
   input  wire logic [ID_BITS-1:0] right_id,
   output logic [KEY_W-1:0]        key,
   output logic [ID_BITS-1:0]      id,
   output logic                    place,
   output logic                    match
);

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [ID_BITS-1:0] id_ff, id_in;

   // new entry belongs at or before this slot (ties go after)
   assign place = !occupied || (key_ff > ctl.key);
   assign match = occupied && (id_ff == new_id);
   assign key   = key_ff;
   assign id    = id_ff;

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (place) begin
               if (left_place) begin
                  key_in = left_key;
                  id_in  = left_id;
               end else begin
                  key_in = ctl.key;
                  id_in  = new_id;
               end
            end
         end
         CELL_SHIFT: begin
            if (rm) begin
               key_in = right_key;
               id_in  = right_id;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

endmodule

`default_nettype wire

/* src/sorted_timeout_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// connection timeouts kept in ascending expiry order in a chain of cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  req_      in         req_valid / req_stall  type, conn id, expiry, now
//  rsp_      out        rsp_valid / rsp_stall  status, expired id, last
//
//  add runs insert then reply, delete find, remove, reply, adjust find, remove, insert, reply
//  tick gives one expired word per cycle while the output is not stalled, popping the head of the chain
//  reset clears the fsm, entry count and output valid; cells need no clearing
//  a stalled output holds its word; requests wait until the fsm is idle
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timeout_queue_assert.svh"

module sorted_timeout_queue import stq_pkg::*; #(
   parameter int TIMER_SLOTS = 64,
   parameter int ID_BITS     = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_type,
   input  wire logic [ID_W-1:0]     req_conn_id,
   input  wire logic [KEY_W-1:0]    req_expire_time,
   input  wire logic [KEY_W-1:0]    req_current_time,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_expired_id,
   output logic                     rsp_last
);

   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

   // fsm and request registers
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   req_kind_type        op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [KEY_W-1:0]    exp_ff, exp_in;
   logic [KEY_W-1:0]    now_ff, now_in;
   status_type          status_ff, status_in;
   logic [TIMER_SLOTS-1:0] match_vec_ff, match_vec_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   // chain wiring
   cell_ctl_type            ctl;
   logic                    shift_all;
   logic [KEY_W-1:0]        cell_key [TIMER_SLOTS];
   logic [ID_BITS-1:0]      cell_id  [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0]  place, match, occ, rm;

   logic out_free, due0, due1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // head and next-to-head due against the tick time
   assign due0 = (count_ff != '0) && (cell_key[0] <= now_ff);
   assign due1 = (count_ff > CNT_W'(1)) && (cell_key[1] <= now_ff);

   generate
      for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
         logic               lp;
         logic [KEY_W-1:0]   lk, rk;
         logic [ID_BITS-1:0] li, ri;

         // occupancy is a thermometer of the entry count
         assign occ[g] = count_ff > CNT_W'(g);
         // a delete or adjust shifts every slot from the first match onward
         assign rm[g]  = shift_all || (|match_vec_ff[g:0]);

         if (g == 0) begin : g_head
            assign lp = 1'b0;
            assign lk = '0;
            assign li = '0;
         end else begin : g_mid
            assign lp = place[g-1];
            assign lk = cell_key[g-1];
            assign li = cell_id[g-1];
         end

         if (g == TIMER_SLOTS - 1) begin : g_tail
            // shifted-in data lands outside the occupied range
            assign rk = cell_key[g];
            assign ri = cell_id[g];
         end else begin : g_body
            assign rk = cell_key[g+1];
            assign ri = cell_id[g+1];
         end

         stq_cell #(
            .ID_BITS (ID_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .new_id     (id_ff),
            .occupied   (occ[g]),
            .rm         (rm[g]),
            .left_place (lp),
            .left_key   (lk),
            .left_id    (li),
            .right_key  (rk),
            .right_id   (ri),
            .key        (cell_key[g]),
            .id         (cell_id[g]),
            .place      (place[g]),
            .match      (match[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      exp_ff        <= exp_in;
      now_ff        <= now_in;
      status_ff     <= status_in;
      match_vec_ff  <= match_vec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      status_in     = status_ff;
      match_vec_in  = match_vec_ff;
      ctl.op        = CELL_HOLD;
      ctl.key       = exp_ff;
      shift_all     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_kind_type'(req_type);
               id_in  = ID_BITS'(req_conn_id);
               exp_in = req_expire_time;
               now_in = req_current_time;
               case (req_kind_type'(req_type)) inside
                  REQ_ADD: begin
                     if (count_ff == CNT_W'(TIMER_SLOTS)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_REPLY;
                     end else begin
                        state_in  = ST_INSERT;
                     end
                  end
                  REQ_ADJUST, REQ_DELETE: state_in = ST_FIND;
                  default:                state_in = ST_TICK;
               endcase
            end
         end
         ST_FIND: begin
            // snapshot which slots carry the id
            match_vec_in = match;
            state_in     = ST_REMOVE;
         end
         ST_REMOVE: begin
            if (|match_vec_ff) begin
               ctl.op   = CELL_SHIFT;
               count_in = count_ff - 1'b1;
               if (op_ff == REQ_ADJUST) begin
                  state_in = ST_INSERT;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = ST_REPLY;
               end
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_REPLY;
            end
         end
         ST_INSERT: begin
            ctl.op    = CELL_INSERT;
            count_in  = count_ff + 1'b1;
            status_in = STATUS_OK;
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (due0) begin
                  // pop the head; last when the next one is not due
                  rsp_status_in = STATUS_EXPIRED;
                  rsp_id_in     = ID_W'(cell_id[0]);
                  rsp_last_in   = !due1;
                  ctl.op        = CELL_SHIFT;
                  shift_all     = 1'b1;
                  count_in      = count_ff - 1'b1;
                  if (!due1) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_status_in = STATUS_NONE;
                  rsp_id_in     = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   `STQ_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(TIMER_SLOTS), "count above capacity")
   `STQ_ASSERT_IMP(a_insert_room, state_ff == ST_INSERT, count_ff < CNT_W'(TIMER_SLOTS), "insert into full chain")
   `STQ_ASSERT_NXT(a_remove_count, (state_ff == ST_REMOVE) && (|match_vec_ff), count_ff == $past(count_ff) - 1'b1, "remove did not drop count")
   `STQ_ASSERT_NXT(a_tick_emits, (state_ff == ST_TICK) && out_free, rsp_valid_ff, "tick cycle produced no word")

endmodule

`default_nettype wire
